/* rtl/core/path_event_point_trigger_core_defines.svh */
// Assertion macros for the path event point trigger RTL, used by the back part.
`ifndef PATH_EVENT_POINT_TRIGGER_CORE_DEFINES_SVH
`define PATH_EVENT_POINT_TRIGGER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define PEPT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define PEPT_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`else

`define PEPT_ASSERT(label, prop, msg)

`define PEPT_ASSERT_NEVER(label, cond, msg)

`endif

`endif

/* rtl/core/pept_pkg.sv */
// Types and constants shared by the path event point trigger modules.
`default_nettype none

package pept_pkg;

   // Operation codes of an input word
   typedef enum logic [1:0] {
      OP_POSITION = 2'd0,
      OP_RESET    = 2'd1,
      OP_LOAD     = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   // Fire modes
   localparam logic [1:0] MODE_ALWAYS  = 2'd0;
   localparam logic [1:0] MODE_FORWARD = 2'd1;
   localparam logic [1:0] MODE_REVERSE = 2'd2;

   // Field widths fixed by the ports
   localparam int DIST_PORT_BITS = 24;
   localparam int DIST_WORD_BITS = 32;
   localparam int SLOT_BITS      = 4;
   localparam int LIMIT_BITS     = 9;
   localparam int ID_BITS        = 4;
   localparam int PASSED_BITS    = 5;
   localparam int COUNT_BITS     = 5;

   localparam logic [PASSED_BITS-1:0] PASSED_NONE = 5'h1F;

   // Register index decoded from paddr[2]
   localparam logic CSR_POINT_COUNT = 1'b0;

   typedef struct packed {
      op_type                        op;
      logic [DIST_WORD_BITS-1:0]     distance;
      logic                          reverse;
      logic [SLOT_BITS-1:0]          slot;
      logic [1:0]                    fire_mode;
      logic signed [LIMIT_BITS-1:0]  fire_limit;
      logic [ID_BITS-1:0]            point_id;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type word;
   } q_word_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_SCAN = 1'b1
   } back_state_type;

endpackage

`default_nettype wire

/* rtl/core/path_event_point_trigger_core.sv */
// Top level of the path event point trigger: register port, front, queue and back.
//
//   channel   ports                  handshake
//   input     start, req_*           taken when start is high and busy is low
//   result    rsp_valid, rsp_*       one cycle per word, cannot be held off
//   config    psel/penable/pwrite    written in the access cycle, pready always high
//
// With the back part idle, a load word passes through the queue register and then the result register.
// A position or reset word scans the table through one registered memory read
// port, one slot per cycle, and stops at the first hit or after point_count
// slots (count held to the table size).
// The two-entry queue takes new words while the back part scans; busy is high when it is full.
// Reset clears control state and the passed slot; table entries are undefined until loaded.
`default_nettype none

module path_event_point_trigger_core #(
   parameter int MAX_POINTS    = 16,
   parameter int DISTANCE_BITS = 24
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      start,
   output logic                                     busy,
   input  wire  [1:0]                               req_operation,
   input  wire  [pept_pkg::DIST_PORT_BITS-1:0]      req_distance,
   input  wire                                      req_reverse,
   input  wire  [pept_pkg::SLOT_BITS-1:0]           req_slot,
   input  wire  [1:0]                               req_fire_mode,
   input  wire signed [pept_pkg::LIMIT_BITS-1:0]    req_fire_limit,
   input  wire  [pept_pkg::ID_BITS-1:0]             req_point_id,
   output logic                                     rsp_valid,
   output logic                                     rsp_fired,
   output logic [pept_pkg::ID_BITS-1:0]             rsp_fired_id,
   output logic [pept_pkg::DIST_PORT_BITS-1:0]      rsp_fired_distance,
   output logic [pept_pkg::PASSED_BITS-1:0]         rsp_passed_slot,
   input  wire                                      psel,
   input  wire                                      penable,
   input  wire                                      pwrite,
   input  wire  [2:0]                               paddr,
   input  wire  [31:0]                              pwdata,
   output logic [31:0]                              prdata,
   output logic                                     pready
);
   import pept_pkg::*;

   logic [COUNT_BITS-1:0] point_count_ff, point_count_in;
   logic                  csr_write;
   logic                  csr_index;
   logic                  queue_full;
   logic                  pop;
   q_word_type            push;
   q_word_type            head;

   assign pready    = 1'b1;
   assign csr_index = paddr[2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      point_count_in = point_count_ff;
      if (csr_write && (csr_index == CSR_POINT_COUNT)) begin
         point_count_in = pwdata[COUNT_BITS-1:0];
      end
      prdata = (csr_index == CSR_POINT_COUNT) ? 32'(point_count_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
      end else begin
         point_count_ff <= point_count_in;
      end
   end

   pept_front #(
      .MAX_POINTS    (MAX_POINTS),
      .DISTANCE_BITS (DISTANCE_BITS)
   ) u_front (
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_distance   (req_distance),
      .req_reverse    (req_reverse),
      .req_slot       (req_slot),
      .req_fire_mode  (req_fire_mode),
      .req_fire_limit (req_fire_limit),
      .req_point_id   (req_point_id),
      .queue_full     (queue_full),
      .push           (push)
   );

   pept_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .head  (head)
   );

   pept_back #(
      .MAX_POINTS    (MAX_POINTS),
      .DISTANCE_BITS (DISTANCE_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .point_count        (point_count_ff),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_fired          (rsp_fired),
      .rsp_fired_id       (rsp_fired_id),
      .rsp_fired_distance (rsp_fired_distance),
      .rsp_passed_slot    (rsp_passed_slot)
   );

endmodule

`default_nettype wire

/* rtl/core/pept_queue.sv */
// Two-entry queue between the front and back parts.
`default_nettype none

module pept_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  pept_pkg::q_word_type push,
   output logic                 full,
   input  wire                  pop,
   output pept_pkg::q_word_type head
);
   import pept_pkg::*;

   work_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && (count_ff != 2'd0);
   assign head.valid = (count_ff != 2'd0);
   assign head.word  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.word;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/pept_front.sv */
// Front part: takes input words, classifies them and pushes them to the queue.
`default_nettype none

module pept_front #(
   parameter int MAX_POINTS    = 16,
   parameter int DISTANCE_BITS = 24
) (
   input  wire                                       start,
   output logic                                      busy,
   input  wire  [1:0]                                req_operation,
   input  wire  [pept_pkg::DIST_PORT_BITS-1:0]       req_distance,
   input  wire                                       req_reverse,
   input  wire  [pept_pkg::SLOT_BITS-1:0]            req_slot,
   input  wire  [1:0]                                req_fire_mode,
   input  wire signed [pept_pkg::LIMIT_BITS-1:0]     req_fire_limit,
   input  wire  [pept_pkg::ID_BITS-1:0]              req_point_id,
   input  wire                                       queue_full,
   output pept_pkg::q_word_type                      push
);
   import pept_pkg::*;

   logic [DISTANCE_BITS-1:0] dist_masked;
   logic                     slot_in_range;
   op_type                   op;

   assign busy          = queue_full;
   assign dist_masked   = DISTANCE_BITS'(req_distance);
   assign slot_in_range = ({3'b000, req_slot} < 7'(MAX_POINTS));

   always_comb begin
      case (req_operation)
         OP_POSITION: op = OP_POSITION;
         OP_RESET:    op = OP_RESET;
         // drop loads aimed past the table
         OP_LOAD:     op = slot_in_range ? OP_LOAD : OP_NONE;
         default:     op = OP_NONE;
      endcase
   end

   always_comb begin
      push.valid           = start && !queue_full;
      push.word.op         = op;
      push.word.distance   = DIST_WORD_BITS'(dist_masked);
      push.word.reverse    = req_reverse;
      push.word.slot       = req_slot;
      push.word.fire_mode  = req_fire_mode;
      push.word.fire_limit = req_fire_limit;
      push.word.point_id   = req_point_id;
   end

endmodule

`default_nettype wire

/* rtl/core/pept_back.sv */
// Back part: point table memory, slot scan, fire decision and result register.
`default_nettype none

`include "path_event_point_trigger_core_defines.svh"

module pept_back #(
   parameter int MAX_POINTS    = 16,
   parameter int DISTANCE_BITS = 24
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire  [pept_pkg::COUNT_BITS-1:0]          point_count,
   input  pept_pkg::q_word_type                     head,
   output logic                                     pop,
   output logic                                     rsp_valid,
   output logic                                     rsp_fired,
   output logic [pept_pkg::ID_BITS-1:0]             rsp_fired_id,
   output logic [pept_pkg::DIST_PORT_BITS-1:0]      rsp_fired_distance,
   output logic [pept_pkg::PASSED_BITS-1:0]         rsp_passed_slot
);
   import pept_pkg::*;

   localparam int IDX_BITS = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_BITS = $clog2(MAX_POINTS + 1);

   // point table
   logic [DISTANCE_BITS-1:0]    mem_dist_ff [MAX_POINTS];
   logic [1:0]                  mem_mode_ff [MAX_POINTS];
   logic signed [LIMIT_BITS-1:0] mem_rem_ff [MAX_POINTS];
   logic [ID_BITS-1:0]          mem_id_ff   [MAX_POINTS];

   logic [DISTANCE_BITS-1:0]     rd_dist_ff;
   logic [1:0]                   rd_mode_ff;
   logic signed [LIMIT_BITS-1:0] rd_rem_ff;
   logic [ID_BITS-1:0]           rd_id_ff;

   back_state_type          state_ff, state_in;
   work_type                cur_ff, cur_in;
   logic [CNT_BITS-1:0]     left_ff, left_in;
   logic [IDX_BITS-1:0]     addr_ff, addr_in;
   logic                    rd_v_ff, rd_v_in;
   logic [IDX_BITS-1:0]     rd_idx_ff, rd_idx_in;
   logic                    lp_valid_ff, lp_valid_in;
   logic [IDX_BITS-1:0]     lp_idx_ff, lp_idx_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_fired_ff, rsp_fired_in;
   logic [ID_BITS-1:0]      rsp_fired_id_ff, rsp_fired_id_in;
   logic [DIST_PORT_BITS-1:0] rsp_fired_dist_ff, rsp_fired_dist_in;
   logic [PASSED_BITS-1:0]  rsp_passed_ff, rsp_passed_in;

   logic [6:0]                   count_wide;
   logic [6:0]                   count_sat;
   logic [CNT_BITS-1:0]          n_points;
   logic [DISTANCE_BITS-1:0]     pos;
   logic                         hit;
   logic                         allow;
   logic                         rd_en;
   logic                         wr_all;
   logic                         wr_rem;
   logic [IDX_BITS-1:0]          wr_addr;
   logic signed [LIMIT_BITS-1:0] wr_rem_data;
   logic                         finish;

   // clamp the count to the table size
   assign count_wide = {2'b00, point_count};
   assign count_sat  = (count_wide > 7'(MAX_POINTS)) ? 7'(MAX_POINTS) : count_wide;
   assign n_points   = CNT_BITS'(count_sat);

   assign pos   = cur_ff.distance[DISTANCE_BITS-1:0];
   assign hit   = cur_ff.reverse ? (pos < rd_dist_ff) : (pos > rd_dist_ff);
   assign allow = (rd_mode_ff == MODE_ALWAYS) ||
                  ((rd_mode_ff == MODE_FORWARD) && !cur_ff.reverse) ||
                  ((rd_mode_ff == MODE_REVERSE) && cur_ff.reverse);

   always_comb begin
      state_in          = state_ff;
      cur_in            = cur_ff;
      left_in           = left_ff;
      addr_in           = addr_ff;
      rd_v_in           = 1'b0;
      rd_idx_in         = rd_idx_ff;
      rd_en             = 1'b0;
      lp_valid_in       = lp_valid_ff;
      lp_idx_in         = lp_idx_ff;
      pop               = 1'b0;
      wr_all            = 1'b0;
      wr_rem            = 1'b0;
      wr_addr           = rd_idx_ff;
      wr_rem_data       = rd_rem_ff - 9'sd1;
      finish            = 1'b0;
      rsp_fired_in      = 1'b0;
      rsp_fired_id_in   = '0;
      rsp_fired_dist_in = '0;
      case (state_ff)
         BK_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               case (head.word.op)
                  OP_LOAD: begin
                     wr_all  = 1'b1;
                     wr_addr = IDX_BITS'(head.word.slot);
                     finish  = 1'b1;
                  end
                  OP_POSITION, OP_RESET: begin
                     cur_in   = head.word;
                     left_in  = n_points;
                     addr_in  = head.word.reverse ? '0 : IDX_BITS'(n_points - 1'b1);
                     state_in = BK_SCAN;
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         BK_SCAN: begin
            if (rd_v_ff && hit) begin
               finish   = 1'b1;
               state_in = BK_IDLE;
               if (cur_ff.op == OP_RESET) begin
                  lp_valid_in = 1'b1;
                  lp_idx_in   = rd_idx_ff;
               end else if (!lp_valid_ff || (rd_idx_ff != lp_idx_ff)) begin
                  lp_valid_in = 1'b1;
                  lp_idx_in   = rd_idx_ff;
                  if (allow && (rd_rem_ff != '0)) begin
                     rsp_fired_in      = 1'b1;
                     rsp_fired_id_in   = rd_id_ff;
                     rsp_fired_dist_in = DIST_PORT_BITS'(rd_dist_ff);
                     // negative count is unlimited
                     wr_rem            = !rd_rem_ff[LIMIT_BITS-1];
                  end
               end
            end else if (left_ff == '0) begin
               finish   = 1'b1;
               state_in = BK_IDLE;
               if (cur_ff.op == OP_RESET) begin
                  lp_valid_in = 1'b0;
               end
            end else begin
               rd_en     = 1'b1;
               rd_v_in   = 1'b1;
               rd_idx_in = addr_ff;
               left_in   = left_ff - 1'b1;
               addr_in   = cur_ff.reverse ? (addr_ff + 1'b1) : (addr_ff - 1'b1);
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      rsp_valid_in  = finish;
      rsp_passed_in = lp_valid_in ? PASSED_BITS'(lp_idx_in) : PASSED_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rd_v_ff      <= 1'b0;
         lp_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_fired_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_v_ff      <= rd_v_in;
         lp_valid_ff  <= lp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_fired_ff <= rsp_fired_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff            <= cur_in;
      left_ff           <= left_in;
      addr_ff           <= addr_in;
      rd_idx_ff         <= rd_idx_in;
      lp_idx_ff         <= lp_idx_in;
      rsp_fired_id_ff   <= rsp_fired_id_in;
      rsp_fired_dist_ff <= rsp_fired_dist_in;
      rsp_passed_ff     <= rsp_passed_in;
   end

   // table write and registered read
   always_ff @(posedge clock) begin
      if (wr_all) begin
         mem_dist_ff[wr_addr] <= head.word.distance[DISTANCE_BITS-1:0];
         mem_mode_ff[wr_addr] <= head.word.fire_mode;
         mem_id_ff[wr_addr]   <= head.word.point_id;
      end
      if (wr_all || wr_rem) begin
         mem_rem_ff[wr_addr] <= wr_all ? head.word.fire_limit : wr_rem_data;
      end
      if (rd_en) begin
         rd_dist_ff <= mem_dist_ff[addr_ff];
         rd_mode_ff <= mem_mode_ff[addr_ff];
         rd_rem_ff  <= mem_rem_ff[addr_ff];
         rd_id_ff   <= mem_id_ff[addr_ff];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_fired          = rsp_fired_ff;
   assign rsp_fired_id       = rsp_fired_id_ff;
   assign rsp_fired_distance = rsp_fired_dist_ff;
   assign rsp_passed_slot    = rsp_passed_ff;

   `PEPT_ASSERT(a_scan_end_gives_word,
      ((state_ff == BK_SCAN) && (state_in == BK_IDLE)) |=> rsp_valid_ff,
      "scan ended without a result word")
   `PEPT_ASSERT(a_fire_records_slot,
      rsp_fired_ff |-> (rsp_valid_ff && (rsp_passed_slot != PASSED_NONE)),
      "fired without a recorded passed slot")
   `PEPT_ASSERT(a_read_data_requested, rd_v_ff |-> $past(rd_en),
      "compare on read data that was never requested")
   `PEPT_ASSERT_NEVER(a_scan_within_table,
      (state_ff == BK_SCAN) && (left_ff > CNT_BITS'(MAX_POINTS)),
      "scan runs past the table")

endmodule

`default_nettype wire
